@@ hdl/cbd_pkg.sv @@
// Shared types, codes and the hex digit decoder for the chunked body decoder.
// No dependencies; every other file imports this package.
package cbd_pkg;

  // decoder phase, one-hot
  typedef enum logic [3:0] {
    PH_SIZE  = 4'b0001,
    PH_DATA  = 4'b0010,
    PH_TRAIL = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  // decode status codes as seen on the port
  typedef enum logic [1:0] {
    ST_RUN      = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_TRUNC    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // classified request handed from front to back
  typedef struct packed {
    logic [7:0] body_byte;
    logic       eoi;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_cr;
    logic       is_lf;
  } cls_t;

  // queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  // hex digit decode: bit 4 flags a valid digit, bits 3:0 its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end
    return r;
  endfunction

endpackage

@@ hdl/cbd_front.sv @@
// Front end: takes raw body bytes and classifies them into cls_t requests.
// Depends on cbd_pkg.
module cbd_front import cbd_pkg::*; (
  input  logic [7:0] in_body_byte,
  input  logic       in_end_of_input,
  output cls_t       cls
);

  logic [4:0] hex;

  // classify the byte once; the back end sees these flags and the byte itself
  always_comb begin
    hex           = hex_decode(in_body_byte);
    cls.body_byte = in_body_byte;
    cls.eoi       = in_end_of_input;
    cls.is_hex    = hex[4];
    cls.hex_val   = hex[3:0];
    cls.is_cr     = (in_body_byte == CHAR_CR);
    cls.is_lf     = (in_body_byte == CHAR_LF);
  end

endmodule

@@ hdl/cbd_queue.sv @@
// Short request queue between the front and back ends.
// Depends on cbd_pkg for cls_t and the queue depth.
module cbd_queue import cbd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cls_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cls_t pop_data
);

  cls_t              mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0]   cnt_r;
  logic              push, pop;

  assign push_ready = (cnt_r != Q_CW'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + Q_CW'(push) - Q_CW'(pop);
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CW'(Q_DEPTH)) else $error("queue count out of range");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> cnt_r == $past(cnt_r) + Q_CW'($past(push)) - Q_CW'($past(pop)))
    else $error("queue count does not track push/pop");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == Q_CW'(Q_DEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers inconsistent with count");

endmodule

@@ hdl/cbd_back.sv @@
// Back end: chunk framing state machine and the registered result stage.
// Depends on cbd_pkg; pops classified requests from cbd_queue.
module cbd_back import cbd_pkg::*; #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  cls_t        pop_data,
  output logic [7:0]  out_payload_byte,
  output logic        out_payload_valid,
  output logic [1:0]  out_decode_status,
  output logic [31:0] out_payload_total,
  output logic        out_valid,
  input  logic        out_ready
);

  phase_t                 phase_r, phase_nxt;
  status_t                status_r, status_nxt;
  logic [SIZE_BITS-1:0]   acc_r, acc_nxt;
  logic [SIZE_BITS-1:0]   left_r, left_nxt;
  logic                   hex_stop_r, hex_stop_nxt;
  logic                   prev_cr_r, prev_cr_nxt;
  logic                   trail_r, trail_nxt;
  logic [31:0]            total_r, total_nxt;
  logic                   oval_r;
  logic [7:0]             obyte_r, obyte_nxt;
  logic                   opv_r, opv_nxt;
  logic                   fire;

  assign pop_ready = !oval_r || out_ready;
  assign fire      = pop_valid && pop_ready;

  // framing state update for one request
  always_comb begin
    phase_nxt    = phase_r;
    status_nxt   = status_r;
    acc_nxt      = acc_r;
    left_nxt     = left_r;
    hex_stop_nxt = hex_stop_r;
    prev_cr_nxt  = prev_cr_r;
    trail_nxt    = trail_r;
    total_nxt    = total_r;
    obyte_nxt    = 8'd0;
    opv_nxt      = 1'b0;
    if (status_r == ST_RUN) begin
      if (pop_data.eoi) begin
        status_nxt = (phase_r == PH_SIZE || phase_r == PH_DATA) ? ST_TRUNC : ST_COMPLETE;
      end else begin
        case (phase_r)
          PH_SIZE: begin
            if (pop_data.is_lf && prev_cr_r) begin
              // CR LF ends the size line
              if (acc_r == '0) begin
                phase_nxt = PH_DONE;
              end else begin
                left_nxt  = acc_r;
                phase_nxt = PH_DATA;
              end
              prev_cr_nxt = 1'b0;
            end else if (!hex_stop_r && pop_data.is_hex) begin
              if (acc_r[SIZE_BITS-1 -: 4] != 4'd0) begin
                status_nxt = ST_OVERFLOW;
              end else begin
                acc_nxt     = {acc_r[SIZE_BITS-5:0], pop_data.hex_val};
                prev_cr_nxt = pop_data.is_cr;
              end
            end else begin
              // extension or line end: stop gathering digits
              hex_stop_nxt = 1'b1;
              prev_cr_nxt  = pop_data.is_cr;
            end
          end
          PH_DATA: begin
            opv_nxt   = 1'b1;
            obyte_nxt = pop_data.body_byte;
            if (total_r != 32'hFFFF_FFFF) total_nxt = total_r + 32'd1;
            if (left_r != '0) left_nxt = left_r - 1'b1;
            if (left_r == '0 || left_r == SIZE_BITS'(1)) begin
              phase_nxt = PH_TRAIL;
              trail_nxt = 1'b0;
            end
          end
          PH_TRAIL: begin
            // two bytes after the data are skipped unchecked
            if (trail_r) begin
              trail_nxt    = 1'b0;
              phase_nxt    = PH_SIZE;
              acc_nxt      = '0;
              hex_stop_nxt = 1'b0;
              prev_cr_nxt  = 1'b0;
            end else begin
              trail_nxt = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SIZE;
      status_r   <= ST_RUN;
      acc_r      <= '0;
      left_r     <= '0;
      hex_stop_r <= 1'b0;
      prev_cr_r  <= 1'b0;
      trail_r    <= 1'b0;
      total_r    <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      status_r   <= status_nxt;
      acc_r      <= acc_nxt;
      left_r     <= left_nxt;
      hex_stop_r <= hex_stop_nxt;
      prev_cr_r  <= prev_cr_nxt;
      trail_r    <= trail_nxt;
      total_r    <= total_nxt;
    end
  end

  // result register; status and total change only when it loads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else if (fire) begin
      oval_r <= 1'b1;
    end else if (out_ready) begin
      oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      obyte_r <= obyte_nxt;
      opv_r   <= opv_nxt;
    end
  end

  assign out_valid         = oval_r;
  assign out_payload_byte  = obyte_r;
  assign out_payload_valid = opv_r;
  assign out_decode_status = status_r;
  assign out_payload_total = total_r;

  a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r != ST_RUN) |=> status_r == $past(status_r))
    else $error("final status changed");

  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> total_r >= $past(total_r)) else $error("payload total decreased");

  a_payload_running: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && opv_r) |-> status_r == ST_RUN)
    else $error("payload byte issued with final status");

endmodule

@@ hdl/chunked_body_decoder_core.sv @@
// Chunked body decoder: one raw body byte in, one result out per byte.
// Path: each byte is written into a queue slot at accept, then popped into the
// result register that drives out_valid; a stalled output holds it in the queue.
// Throughput: 1 byte per cycle while out_ready keeps up, set by the back end framing.
// Reset: synchronous on rst_n low; all framing state clears at once, no clearing pass.
// Depends on cbd_pkg, cbd_front, cbd_queue and cbd_back.
module chunked_body_decoder_core import cbd_pkg::*; #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_body_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_payload_byte,
  output logic        out_payload_valid,
  output logic [1:0]  out_decode_status,
  output logic [31:0] out_payload_total
);

  cls_t front_cls, q_data;
  logic q_valid, q_ready;

  cbd_front u_front (
    .in_body_byte    (in_body_byte),
    .in_end_of_input (in_end_of_input),
    .cls             (front_cls)
  );

  cbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_cls),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  cbd_back #(.SIZE_BITS(SIZE_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .pop_valid         (q_valid),
    .pop_ready         (q_ready),
    .pop_data          (q_data),
    .out_payload_byte  (out_payload_byte),
    .out_payload_valid (out_payload_valid),
    .out_decode_status (out_decode_status),
    .out_payload_total (out_payload_total),
    .out_valid         (out_valid),
    .out_ready         (out_ready)
  );

endmodule

@@ bench/cbd_result_checker.sv @@
// Scoreboard for the chunked body decoder: watches both channels, predicts each result.
// Depends on cbd_pkg for the phase and status codes and the CR/LF constants.
module cbd_result_checker import cbd_pkg::*; #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_body_byte,
  input  logic        in_end_of_input,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_payload_byte,
  input  logic        out_payload_valid,
  input  logic [1:0]  out_decode_status,
  input  logic [31:0] out_payload_total,
  output int          results_owed,
  output int          fail_count
);

  typedef struct packed {
    logic [7:0]  data;
    logic        is_payload;
    status_t     status;
    logic [31:0] total;
  } decoded_t;

  // decoder state as predicted
  phase_t      ph;
  logic [63:0] size_acc;
  logic [63:0] left_in_chunk;
  logic        hex_done;
  logic        cr_seen;
  logic        trail_half;
  status_t     st;
  logic [31:0] total_seen;

  decoded_t decoded_due[$];
  int       mismatches = 0;

  assign fail_count = mismatches;

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void open_size_line();
    ph       = PH_SIZE;
    size_acc = '0;
    hex_done = 1'b0;
    cr_seen  = 1'b0;
  endfunction

  // one byte on the size line: digits, then anything up to CR LF
  function automatic void size_line_step(input logic [7:0] c);
    int nib;
    nib = nibble_of(c);
    if (c == CHAR_LF && cr_seen) begin
      if (size_acc == 0) begin
        ph = PH_DONE;
      end else begin
        left_in_chunk = size_acc;
        ph = PH_DATA;
      end
      cr_seen = 1'b0;
    end else if (!hex_done && nib >= 0 && (size_acc >> (SIZE_BITS - 4)) != 0) begin
      // digit would not fit: sticky overflow, size left as is
      st = ST_OVERFLOW;
    end else begin
      if (!hex_done && nib >= 0) begin
        size_acc = (size_acc << 4) | 64'(nib);
      end else begin
        hex_done = 1'b1;
      end
      cr_seen = (c == CHAR_CR);
    end
  endfunction

  // advance the predicted decoder by one request, return its result
  function automatic decoded_t decode_next_byte(input logic [7:0] c, input logic eoi);
    decoded_t r;
    r = '{data: 8'h00, is_payload: 1'b0, status: ST_RUN, total: 32'h0};
    if (st == ST_RUN) begin
      if (eoi) begin
        if (ph == PH_SIZE || ph == PH_DATA) st = ST_TRUNC;
        else st = ST_COMPLETE;
      end else begin
        case (ph)
          PH_SIZE: size_line_step(c);
          PH_DATA: begin
            r.is_payload = 1'b1;
            r.data       = c;
            if (total_seen != 32'hFFFF_FFFF) total_seen++;
            if (left_in_chunk != 0) left_in_chunk--;
            if (left_in_chunk == 0) begin
              ph         = PH_TRAIL;
              trail_half = 1'b0;
            end
          end
          PH_TRAIL: begin
            // two bytes after each chunk, not checked
            if (trail_half) begin
              trail_half = 1'b0;
              open_size_line();
            end else begin
              trail_half = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
    r.status = st;
    r.total  = total_seen;
    return r;
  endfunction

  // predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    decoded_t got;
    decoded_t want;
    if (!rst_n) begin
      open_size_line();
      left_in_chunk = '0;
      trail_half    = 1'b0;
      st            = ST_RUN;
      total_seen    = '0;
      decoded_due.delete();
      results_owed <= 0;
    end else begin
      if (in_valid && in_ready) begin
        decoded_due.push_back(decode_next_byte(in_body_byte, in_end_of_input));
      end
      if (out_valid && out_ready) begin
        got = '{data: out_payload_byte, is_payload: out_payload_valid,
                status: status_t'(out_decode_status), total: out_payload_total};
        if (decoded_due.size() == 0) begin
          $error("result with no request outstanding: status %0d total %0d",
                 got.status, got.total);
          mismatches++;
        end else begin
          want = decoded_due.pop_front();
          if (got.data !== want.data) begin
            $error("payload_byte: expected %02h, got %02h", want.data, got.data);
            mismatches++;
          end
          if (got.is_payload !== want.is_payload) begin
            $error("payload_valid: expected %0b, got %0b", want.is_payload, got.is_payload);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $error("decode_status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.total !== want.total) begin
            $error("payload_total: expected %0d, got %0d", want.total, got.total);
            mismatches++;
          end
        end
      end
      results_owed <= decoded_due.size();
    end
  end

endmodule

@@ bench/tb_chunked_body_decoder_core.sv @@
// Testbench top for chunked_body_decoder_core: clock, reset, chunked body stimulus, verdict.
// Depends on cbd_pkg, the decoder RTL and cbd_result_checker.
module tb_chunked_body_decoder_core import cbd_pkg::*;;

  localparam int unsigned SIZE_BITS   = 32;
  localparam int          RUN_ITEMS   = 410;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          HOLD_AT     = 200;
  localparam int          HOLD_CYCLES = 64;

  // how the body ends; only one per run since the status is sticky
  typedef enum int {
    END_TRUNC_SIZE,
    END_TRUNC_DATA,
    END_IN_TRAILER,
    END_ZERO_CHUNK,
    END_EMPTY_LINE,
    END_OVERFLOW,
    END_KINDS
  } ending_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_body_byte;
  logic        in_end_of_input;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_payload_byte;
  logic        out_payload_valid;
  logic [1:0]  out_decode_status;
  logic [31:0] out_payload_total;

  int results_owed;
  int fail_count;
  int sent_cnt    = 0;
  int cycles      = 0;
  bit no_gaps     = 1'b0;
  bit rx_holding  = 1'b0;

  chunked_body_decoder_core #(.SIZE_BITS(SIZE_BITS)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_body_byte      (in_body_byte),
    .in_end_of_input   (in_end_of_input),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_payload_byte  (out_payload_byte),
    .out_payload_valid (out_payload_valid),
    .out_decode_status (out_decode_status),
    .out_payload_total (out_payload_total)
  );

  cbd_result_checker #(.SIZE_BITS(SIZE_BITS)) u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_body_byte      (in_body_byte),
    .in_end_of_input   (in_end_of_input),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_payload_byte  (out_payload_byte),
    .out_payload_valid (out_payload_valid),
    .out_decode_status (out_decode_status),
    .out_payload_total (out_payload_total),
    .results_owed      (results_owed),
    .fail_count        (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || rx_holding) return 0;
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bit is_hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
    if (n < 4'd10) return "0" + 8'(n);
    return (upper ? "A" : "a") + 8'(n) - 8'd10;
  endfunction

  // mostly short chunks, a few longer ones
  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 8);
    if (r < 97) return $urandom_range(9, 40);
    return $urandom_range(41, 120);
  endfunction

  // one request: optional gap, then hold valid until accepted
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_body_byte    <= b;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
  endtask

  // sender goes quiet until every result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // hex size with optional leading zeros and mixed case
  task automatic send_size(input logic [31:0] value, input int zeros);
    int          ndig;
    logic [31:0] t;
    ndig = 1;
    t    = value >> 4;
    while (t != 0) begin
      ndig++;
      t = t >> 4;
    end
    repeat (zeros) send_byte("0", 1'b0);
    for (int i = ndig - 1; i >= 0; i--) begin
      send_byte(hex_char(value[4*i +: 4], 1'($urandom_range(0, 1))), 1'b0);
    end
  endtask

  // chunk extension: non-hex lead, then junk with lone CRs and bare LFs, never CR LF
  task automatic send_ext();
    logic [7:0] b;
    logic [7:0] prev;
    int         n;
    if ($urandom_range(0, 2) == 0) return;
    do b = 8'($urandom_range(0, 255)); while (is_hex_char(b));
    send_byte(b, 1'b0);
    prev = b;
    n = $urandom_range(0, 6);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0:       b = CHAR_CR;
        1:       b = CHAR_LF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      if (b == CHAR_LF && prev == CHAR_CR) b = ";";
      send_byte(b, 1'b0);
      prev = b;
    end
  endtask

  task automatic send_crlf();
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_LF, 1'b0);
  endtask

  task automatic send_data(input int n);
    repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // full chunk; the two bytes after the data are usually CR LF, sometimes junk
  task automatic send_chunk(input logic [31:0] size);
    send_size(size, $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
    send_ext();
    send_crlf();
    send_data(size);
    if ($urandom_range(0, 5) == 0) send_data(2);
    else send_crlf();
  endtask

  // close out the body; the block is at the start of a size line here
  task automatic send_ending(input ending_t kind);
    logic [31:0] sz;
    case (kind)
      END_TRUNC_SIZE: begin
        send_size(pick_size(), 0);
        if ($urandom_range(0, 1)) send_ext();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      END_TRUNC_DATA: begin
        // largest size that fits, cut short
        send_size(32'hFFFF_FFFF, 0);
        send_crlf();
        send_data($urandom_range(1, 6));
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      END_IN_TRAILER: begin
        sz = $urandom_range(1, 4);
        send_size(sz, 0);
        send_crlf();
        send_data(sz);
        if ($urandom_range(0, 1)) send_byte(CHAR_CR, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      END_ZERO_CHUNK: begin
        send_size(32'h0, $urandom_range(0, 2));
        send_ext();
        send_crlf();
        // trailer header, ignored
        send_byte("X", 1'b0);
        send_byte(":", 1'b0);
        send_byte("1", 1'b0);
        send_crlf();
        send_crlf();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      END_EMPTY_LINE: begin
        send_crlf();
        send_data($urandom_range(1, 4));
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      default: begin
        // ninth significant digit does not fit
        send_size($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h1000_0000, 0);
        send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
  endtask

  // receiver: random stalls, one long hold-off, some windows always ready
  initial begin
    int  r;
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_done  = 1'b1;
        hold_left  = HOLD_CYCLES;
        rx_holding = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
        if (hold_left == 0) rx_holding = 1'b0;
      end else if ((sent_cnt / 60) % 4 == 2) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          hold_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 30);
        end
      end
    end
  end

  // stimulus and verdict
  initial begin
    int directed_end;
    in_valid        <= 1'b0;
    in_body_byte    <= 8'h00;
    in_end_of_input <= 1'b0;
    rst_n           <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // size "0a" with leading zero, extension holding a bare LF and a lone CR
    send_byte("0", 1'b0);
    send_byte("a", 1'b0);
    send_byte(";", 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_byte("z", 1'b0);
    send_crlf();
    // payload extremes and framing characters passed through as data
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_byte("0", 1'b0);
    send_byte("F", 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_crlf();
    wait_drained();
    directed_end = sent_cnt;

    // long run of well-formed chunks with random content
    while (sent_cnt < directed_end + RUN_ITEMS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      send_chunk(pick_size());
      if ($urandom_range(0, 30) == 0) wait_drained();
    end
    no_gaps = 1'b0;

    send_ending(ending_t'($urandom_range(0, END_KINDS - 1)));
    // status is sticky: these must all be ignored
    repeat ($urandom_range(2, 4)) begin
      send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/cbd_pkg.sv
hdl/cbd_front.sv
hdl/cbd_queue.sv
hdl/cbd_back.sv
hdl/chunked_body_decoder_core.sv
bench/cbd_result_checker.sv
bench/tb_chunked_body_decoder_core.sv
